// ----- hdl/assert_macros.svh -----
// Assertion macros used by the heap priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define CHK_IMPLY(lbl, clk, rst_n, a, b, msg)
`define CHK_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

// ----- hdl/bmhpq_pkg.sv -----
// Request and result types and operation codes of the heap priority queue.
`timescale 1ns / 1ps
package bmhpq_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [31:0] top_key;
        logic [31:0] top_payload;
        logic        found;
        logic        rejected;
        logic [6:0]  occupancy;
    } resp_t;

endpackage

// ----- hdl/binary_min_heap_priority_queue.sv -----
// Binary min-heap priority queue built around one entry memory.
//
//  channel   signals               handshake
//  request   request (req_t)       taken at a clock edge with start high, busy low
//  result    result (resp_t)       valid for the one cycle that done is high
//
// Peek and operations on an empty or full heap finish without a walk. Pop first
// fetches the root and the last entry. Push and pop then move the entry through L
// levels (at most log2(CAPACITY)); each level costs one read-modify-write of the
// entry memory, and the moving entry is then written where it comes to rest.
// Reset clears the state, the entry count and done; the memory needs no clearing pass.
// The receiver cannot stall; busy holds off requests while a walk runs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module binary_min_heap_priority_queue
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  req_t  request,
    output logic  done,
    output resp_t result
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = IW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RISE  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_SINK  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    entry_t mem [CAPACITY];

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] pos_reg, pos_next;
    entry_t        hold_reg, hold_next;
    logic [1:0]    op_reg, op_next;
    resp_t         resp_reg, resp_next;
    logic          done_reg, done_next;

    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    logic [IW-1:0] raddr0, raddr1;
    entry_t        rd0_reg, rd1_reg;

    logic [IW:0]   child_c, child_r, next_c;
    logic          take_r;
    entry_t        child;
    logic [IW-1:0] pick;
    logic [CW-1:0] cnt_dec;

    function automatic logic [IW-1:0] parent_of(logic [IW-1:0] p);
        return (p - IW'(1)) >> 1;
    endfunction

    function automatic logic [6:0] occ_of(logic [CW-1:0] c);
        logic [CW+6:0] e;
        e = {7'b0, c};
        return e[6:0];
    endfunction

    function automatic logic [31:0] key_out(logic [KEY_BITS-1:0] k);
        logic [31:0] v;
        v = '0;
        v[KEY_BITS-1:0] = k;
        return v;
    endfunction

    function automatic logic [31:0] pay_out(logic [PAYLOAD_BITS-1:0] p);
        logic [31:0] v;
        v = '0;
        v[PAYLOAD_BITS-1:0] = p;
        return v;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    assign cnt_dec = count_reg - CW'(1);
    assign child_c = {pos_reg, 1'b1};
    assign child_r = child_c + (IW + 1)'(1);
    assign take_r  = (CMPW'(child_r) < CMPW'(count_reg)) && (rd1_reg.key < rd0_reg.key);
    assign child   = take_r ? rd1_reg : rd0_reg;
    assign pick    = take_r ? child_r[IW-1:0] : child_c[IW-1:0];
    assign next_c  = {pick, 1'b1};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        hold_next  = hold_reg;
        op_next    = op_reg;
        resp_next  = resp_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = hold_reg;
        raddr0     = '0;
        raddr1     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    resp_next = '0;
                    case (request.op)
                        OP_PUSH:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                resp_next.rejected = 1'b1;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                hold_next.key     = request.key[KEY_BITS-1:0];
                                hold_next.payload = request.payload[PAYLOAD_BITS-1:0];
                                pos_next          = count_reg[IW-1:0];
                                count_next        = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    we        = 1'b1;
                                    waddr     = '0;
                                    wdata     = hold_next;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    raddr0     = parent_of(count_reg[IW-1:0]);
                                    state_next = S_RISE;
                                end
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                op_next    = request.op;
                                raddr0     = '0;
                                raddr1     = cnt_dec[IW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RISE:
            begin
                // rd0 holds the parent of the hole at pos
                if (rd0_reg.key > hold_reg.key)
                begin
                    we       = 1'b1;
                    wdata    = rd0_reg;
                    pos_next = parent_of(pos_reg);
                    if (pos_next == '0)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        raddr0 = parent_of(pos_next);
                    end
                end
                else
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                resp_next.top_key     = key_out(rd0_reg.key);
                resp_next.top_payload = pay_out(rd0_reg.payload);
                resp_next.found       = 1'b1;
                if (op_reg == OP_PEEK)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = cnt_dec;
                    hold_next  = rd1_reg;
                    pos_next   = '0;
                    if (cnt_dec == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (cnt_dec == CW'(1))
                    begin
                        // last entry lands in the root, nothing to sink
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = rd1_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        raddr0     = IW'(1);
                        raddr1     = IW'(2);
                        state_next = S_SINK;
                    end
                end
            end
            S_SINK:
            begin
                if (child.key < hold_reg.key)
                begin
                    we       = 1'b1;
                    wdata    = child;
                    pos_next = pick;
                    if (CMPW'(next_c) < CMPW'(count_reg))
                    begin
                        raddr0 = next_c[IW-1:0];
                        raddr1 = next_c[IW-1:0] + IW'(1);
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                we         = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            resp_next.occupancy = occ_of(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        op_reg   <= op_next;
        resp_reg <= resp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = resp_reg;

    `CHK_IMPLY(a_count_cap, clk, rst_n, 1'b1, count_reg <= CAP_CNT, "entry count above capacity")
    `CHK_IMPLY(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result while walk runs")
    `CHK_IMPLY(a_found_rej, clk, rst_n, done_reg, !(resp_reg.found && resp_reg.rejected), "found and rejected together")
    `CHK_NEXT(a_req_moves, clk, rst_n, start && !busy, busy || done_reg, "request neither answered nor started")

endmodule

// ----- sim/tb_binary_min_heap_priority_queue.sv -----
// Self-checking testbench of the binary min-heap priority queue.
`timescale 1ns / 1ps
module tb_binary_min_heap_priority_queue;
    import bmhpq_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        req_t  req;
        bit    typed;
        resp_t want;
    } step_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  request;
    logic  done;
    resp_t result;

    // expectation typed into the directed table, travels with its request
    bit    tag_typed;
    resp_t tag_want;

    // predictor state
    logic [31:0] heap_key [CAPACITY];
    logic [31:0] heap_pay [CAPACITY];
    int          heap_size;

    resp_t expected_results[$];
    step_t directed_steps[$];
    int    accepted_count;
    int    items_sent;
    int    error_count;
    int    results_seen;
    int    idle_cycles;
    int    pushes_rejected;
    int    empty_reads;
    int    peak_occupancy;

    binary_min_heap_priority_queue #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (32),
        .PAYLOAD_BITS (32)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void swap_slots(int a, int b);
        logic [31:0] k;
        logic [31:0] p;
        k = heap_key[a];
        p = heap_pay[a];
        heap_key[a] = heap_key[b];
        heap_pay[a] = heap_pay[b];
        heap_key[b] = k;
        heap_pay[b] = p;
    endfunction

    // Apply one request to the predicted heap and return its result.
    function automatic resp_t apply_heap_op(req_t r);
        resp_t o;
        int    pos;
        int    up;
        int    kid;
        o = '0;
        case (r.op)
            OP_PUSH:
            begin
                if (heap_size >= CAPACITY)
                begin
                    o.rejected = 1'b1;
                    pushes_rejected++;
                end
                else
                begin
                    heap_key[heap_size] = r.key;
                    heap_pay[heap_size] = r.payload;
                    pos = heap_size;
                    heap_size++;
                    while (pos > 0)
                    begin
                        up = (pos - 1) / 2;
                        if (heap_key[up] <= heap_key[pos])
                            break;
                        swap_slots(up, pos);
                        pos = up;
                    end
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (heap_size == 0)
                    empty_reads++;
                else
                begin
                    o.found       = 1'b1;
                    o.top_key     = heap_key[0];
                    o.top_payload = heap_pay[0];
                    if (r.op == OP_POP)
                    begin
                        heap_size--;
                        if (heap_size > 0)
                        begin
                            heap_key[0] = heap_key[heap_size];
                            heap_pay[0] = heap_pay[heap_size];
                            pos = 0;
                            kid = 1;
                            // sink; the right child wins only when strictly smaller
                            while (kid < heap_size)
                            begin
                                if (kid + 1 < heap_size && heap_key[kid + 1] < heap_key[kid])
                                    kid = kid + 1;
                                if (heap_key[kid] >= heap_key[pos])
                                    break;
                                swap_slots(kid, pos);
                                pos = kid;
                                kid = 2 * kid + 1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        o.occupancy = 7'(heap_size);
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s got 0x%08h, expected 0x%08h",
                 $time, results_seen, field, got, want);
        error_count++;
    endtask

    task automatic check_result(resp_t got, resp_t want);
        if (got.top_key !== want.top_key)
            report_mismatch("top_key", got.top_key, want.top_key);
        if (got.top_payload !== want.top_payload)
            report_mismatch("top_payload", got.top_payload, want.top_payload);
        if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.rejected !== want.rejected)
            report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
        if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
    endtask

    // Take requests, predict, check results, and watch for a stuck block.
    always @(posedge clk)
    begin
        resp_t want;
        bit    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                want = apply_heap_op(request);
                if (tag_typed)
                    want = tag_want;
                expected_results.push_back(want);
                accepted_count <= accepted_count + 1;
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                    report_mismatch("result with no request pending", 32'd1, 32'd0);
                else
                    check_result(result, expected_results.pop_front());
                if (result.occupancy > peak_occupancy)
                    peak_occupancy = result.occupancy;
                results_seen++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic issue(req_t r, bit typed, resp_t want, bit burst);
        int gap;
        int taken;
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        request   <= r;
        tag_typed <= typed;
        tag_want  <= want;
        taken = accepted_count;
        do
            @(negedge clk);
        while (accepted_count == taken);
        items_sent++;
    endtask

    task automatic issue_random(int push_pct, bit narrow, bit burst);
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            r.op = OP_PUSH;
        else if (roll < push_pct + 10)
            r.op = OP_PEEK;
        else if (roll < push_pct + 12)
            r.op = OP_NOP;
        else
            r.op = OP_POP;
        r.key = narrow ? 32'($urandom_range(0, 7)) : $urandom;
        if (!narrow && $urandom_range(0, 15) == 0)
            r.key = $urandom_range(0, 1) ? '1 : '0;
        r.payload = $urandom;
        issue(r, 1'b0, '0, burst);
    endtask

    task automatic add_row(logic [1:0] op, logic [31:0] key, logic [31:0] pay,
                           bit typed = 1'b0, logic [31:0] wk = '0, logic [31:0] wp = '0,
                           logic wf = 1'b0, logic wr = 1'b0, logic [6:0] wocc = '0);
        step_t s;
        s.req.op              = op;
        s.req.key             = key;
        s.req.payload         = pay;
        s.typed               = typed;
        s.want.top_key        = wk;
        s.want.top_payload    = wp;
        s.want.found          = wf;
        s.want.rejected       = wr;
        s.want.occupancy      = wocc;
        directed_steps.push_back(s);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int seg;
        int kind;
        int len;
        bit burst;
        bit narrow;

        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        tag_typed       = 1'b0;
        tag_want        = '0;
        heap_size       = 0;
        accepted_count  = 0;
        items_sent      = 0;
        error_count     = 0;
        results_seen    = 0;
        idle_cycles     = 0;
        pushes_rejected = 0;
        empty_reads     = 0;
        peak_occupancy  = 0;

        // empty heap, extremes of key and payload, ties, unsigned ordering
        add_row(OP_PEEK, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        add_row(OP_POP,  '1, '1, 1'b1);
        add_row(OP_NOP,  '1, '1, 1'b1);
        add_row(OP_PUSH, '1, '0, 1'b1, '0, '0, 1'b0, 1'b0, 7'd1);
        add_row(OP_PEEK, '0, '0, 1'b1, '1, '0, 1'b1, 1'b0, 7'd1);
        add_row(OP_PUSH, '0, '1, 1'b1, '0, '0, 1'b0, 1'b0, 7'd2);
        add_row(OP_PEEK, '1, '1, 1'b1, '0, '1, 1'b1, 1'b0, 7'd2);
        add_row(OP_PUSH, 32'd5, 32'h0000_00A1);
        add_row(OP_PUSH, 32'd5, 32'h0000_00A2);
        add_row(OP_PUSH, 32'd5, 32'h0000_00A3);
        add_row(OP_PUSH, 32'd0, 32'h0000_00B1);
        add_row(OP_NOP,  32'd1, 32'h5555_AAAA);
        repeat (6)
            add_row(OP_POP, '0, '0);
        add_row(OP_POP,  '0, '0, 1'b1);
        add_row(OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF);
        add_row(OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(OP_PEEK, '0, '0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 7'd2);
        add_row(OP_POP,  '0, '0);
        add_row(OP_POP,  '0, '0);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
            issue(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want, 1'b0);
        start <= 1'b0;
        wait_drained();

        seg = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind   = (seg % 5 == 0) ? 1 : $urandom_range(0, 3);
            burst  = ($urandom_range(0, 2) == 0);
            narrow = $urandom_range(0, 1);
            len    = $urandom_range(20, 60);
            case (kind)
                0: repeat (len) issue_random(60, 1'b0, burst);
                1:
                begin
                    // fill past capacity, then drain past empty
                    while (heap_size < CAPACITY)
                        issue_random(100, narrow, burst);
                    repeat ($urandom_range(1, 3)) issue_random(100, narrow, burst);
                    while (heap_size > 0)
                        issue_random(0, narrow, burst);
                    repeat ($urandom_range(1, 3)) issue_random(0, narrow, burst);
                end
                2: repeat (len) issue_random(30, 1'b0, burst);
                default: repeat (len) issue_random(55, 1'b1, burst);
            endcase
            if (kind == 1 || $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                wait_drained();
            end
            seg++;
        end

        start <= 1'b0;
        wait_drained();
        repeat (20) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", 32'(expected_results.size()), 32'd0);

        $display("Checked %0d results from %0d requests, peak occupancy %0d.",
                 results_seen, items_sent, peak_occupancy);
        $display("Pushes dropped on a full heap: %0d, pops and peeks on an empty heap: %0d.",
                 pushes_rejected, empty_reads);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
